// File: design/hpz_pkg.sv
// ----------------------------------------------------------------------------
// hpz_pkg
// Shared constants for the histogram peak / zero bin finder.
// ----------------------------------------------------------------------------
package hpz_pkg;

  localparam int NUM_BINS = 256;
  localparam int BIN_W    = 8;
  localparam int CNT_W    = 21;
  localparam int POS_W    = BIN_W + 1;

  localparam longint unsigned MAX_PIXELS = 64'd1048576;
  localparam longint unsigned COUNT_MAX  = (64'd1 << CNT_W) - 64'd1;

  // bin count stops at the smaller of the image size and the counter range
  localparam logic [CNT_W-1:0] COUNT_LIMIT =
    (MAX_PIXELS < COUNT_MAX) ? CNT_W'(MAX_PIXELS) : CNT_W'(COUNT_MAX);

endpackage

// File: design/histogram_peak_zero_finder.sv
// ----------------------------------------------------------------------------
// histogram_peak_zero_finder
// Counts 8-bit pixels into a 256-bin histogram, then finds the peak and zero
// bins of the image.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_pixel and in_last_pixel with start high; the word is taken
//   at a clock edge where busy is low. For each pixel, its bin is first read
//   from the count RAM, then the incremented count is written back.
//   A pixel with in_last_pixel set starts a scan over all 256 bins, one RAM
//   read per cycle into a single compare unit; the result word appears on
//   out_valid for one cycle once the scan is done, and busy falls in that
//   same cycle, so the next image may start there.
//   out_peak_bin / out_zero_bin are the highest bins holding the largest and
//   smallest count; out_count_saturated flags a pixel that met a full bin.
//   The scan empties the histogram for the next image.
//   The RAM read port is the limit on throughput: one bin per cycle.
//   Reset (rst_n low, synchronous) empties the histogram at once through
//   per-bin valid flags; no clearing pass is needed.
//   The receiver cannot stall: out_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module histogram_peak_zero_finder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [hpz_pkg::BIN_W-1:0] in_pixel,
  input  logic                      in_last_pixel,
  output logic                      out_valid,
  output logic [hpz_pkg::BIN_W-1:0] out_peak_bin,
  output logic [hpz_pkg::BIN_W-1:0] out_zero_bin,
  output logic                      out_count_saturated
);

  import hpz_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_SCAN
  } state_t;

  state_t              state_r;
  logic [NUM_BINS-1:0] vld_r;
  logic                vld_q_r;
  logic [BIN_W-1:0]    addr_r;
  logic                last_r;
  logic                sat_r;
  logic [POS_W-1:0]    pos_r;
  logic                pend_r;
  logic [BIN_W-1:0]    idx_r;
  logic [CNT_W-1:0]    hi_cnt_r;
  logic [BIN_W-1:0]    hi_idx_r;
  logic [CNT_W-1:0]    lo_cnt_r;
  logic [BIN_W-1:0]    lo_idx_r;
  logic                out_valid_r;
  logic [BIN_W-1:0]    out_peak_r;
  logic [BIN_W-1:0]    out_zero_r;
  logic                out_sat_r;

  logic [CNT_W-1:0]    hi_cnt_nxt;
  logic [BIN_W-1:0]    hi_idx_nxt;
  logic [CNT_W-1:0]    lo_cnt_nxt;
  logic [BIN_W-1:0]    lo_idx_nxt;

  logic                ram_we;
  logic [BIN_W-1:0]    ram_raddr;
  logic [CNT_W-1:0]    ram_rdata;
  logic [CNT_W-1:0]    cnt;
  logic                accept;
  logic                full;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign ram_raddr = (state_r == S_SCAN) ? pos_r[BIN_W-1:0] : in_pixel;
  assign cnt       = vld_q_r ? ram_rdata : '0;
  assign full      = (cnt >= COUNT_LIMIT);
  assign ram_we    = (state_r == S_UPD) && !full;

  hpz_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (cnt + CNT_W'(1)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // compare unit, ties go to the later bin
  always_comb begin
    hi_cnt_nxt = hi_cnt_r;
    hi_idx_nxt = hi_idx_r;
    lo_cnt_nxt = lo_cnt_r;
    lo_idx_nxt = lo_idx_r;
    if (pend_r) begin
      if (idx_r == '0) begin
        hi_cnt_nxt = cnt;
        hi_idx_nxt = idx_r;
        lo_cnt_nxt = cnt;
        lo_idx_nxt = idx_r;
      end else begin
        if (cnt >= hi_cnt_r) begin
          hi_cnt_nxt = cnt;
          hi_idx_nxt = idx_r;
        end
        if (cnt <= lo_cnt_r) begin
          lo_cnt_nxt = cnt;
          lo_idx_nxt = idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      sat_r       <= 1'b0;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_SCAN) && pos_r[BIN_W];
      vld_q_r     <= vld_r[ram_raddr];
      hi_cnt_r    <= hi_cnt_nxt;
      hi_idx_r    <= hi_idx_nxt;
      lo_cnt_r    <= lo_cnt_nxt;
      lo_idx_r    <= lo_idx_nxt;
      case (state_r)
        S_IDLE: begin
          pend_r <= 1'b0;
          if (accept) begin
            addr_r  <= in_pixel;
            last_r  <= in_last_pixel;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (full) begin
            sat_r <= 1'b1;
          end else begin
            vld_r[addr_r] <= 1'b1;
          end
          pos_r   <= '0;
          state_r <= last_r ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          if (!pos_r[BIN_W]) begin
            pend_r <= 1'b1;
            idx_r  <= pos_r[BIN_W-1:0];
            pos_r  <= pos_r + POS_W'(1);
          end else begin
            pend_r      <= 1'b0;
            out_peak_r  <= hi_idx_nxt;
            out_zero_r  <= lo_idx_nxt;
            out_sat_r   <= sat_r;
            sat_r       <= 1'b0;
            vld_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_peak_bin        = out_peak_r;
  assign out_zero_bin        = out_zero_r;
  assign out_count_saturated = out_sat_r;

endmodule

// File: design/hpz_ram.sv
// ----------------------------------------------------------------------------
// hpz_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hpz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: verif/histogram_peak_zero_finder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_peak_zero_finder_test
// Self-checking bench for the histogram peak / zero bin finder. Pixel words
// are driven through the start/busy handshake. A behavioral histogram
// predicts the peak bin, zero bin and saturation flag of every image, and
// each out_valid strobe is checked against the oldest prediction. Directed
// images cover single pixels and ties. Random images run under three
// sender idle rates, and one image fills every bin.
// ----------------------------------------------------------------------------
module histogram_peak_zero_finder_test;
  import hpz_pkg::*;

  localparam int CYCLE_LIMIT   = 5000000;
  localparam int SCAN_SETTLE   = 300;

  typedef struct packed {
    logic [BIN_W-1:0] peak_bin;
    logic [BIN_W-1:0] zero_bin;
    logic             saturated;
  } image_result_t;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             start         = 1'b0;
  logic             busy;
  logic [BIN_W-1:0] in_pixel      = '0;
  logic             in_last_pixel = 1'b0;
  logic             out_valid;
  logic [BIN_W-1:0] out_peak_bin;
  logic [BIN_W-1:0] out_zero_bin;
  logic             out_count_saturated;

  logic [CNT_W-1:0] bin_count [NUM_BINS];
  logic             sat_seen;
  image_result_t    pending_images[$];

  int idle_pct;
  int pixels_sent;
  int images_sent;
  int results_checked;
  int mismatches;
  int cycles;

  histogram_peak_zero_finder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_pixel            (in_pixel),
    .in_last_pixel       (in_last_pixel),
    .out_valid           (out_valid),
    .out_peak_bin        (out_peak_bin),
    .out_zero_bin        (out_zero_bin),
    .out_count_saturated (out_count_saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // count one pixel; on the last pixel scan, queue the image result and clear
  function automatic void count_pixel(input logic [BIN_W-1:0] px, input logic last);
    logic [CNT_W-1:0] high_cnt;
    logic [CNT_W-1:0] low_cnt;
    image_result_t    r;
    if (bin_count[px] >= COUNT_LIMIT) begin
      bin_count[px] = COUNT_LIMIT;
      sat_seen      = 1'b1;
    end else begin
      bin_count[px] = bin_count[px] + 1'b1;
    end
    if (last) begin
      high_cnt   = bin_count[0];
      low_cnt    = bin_count[0];
      r.peak_bin = '0;
      r.zero_bin = '0;
      for (int b = 0; b < NUM_BINS; b++) begin
        if (bin_count[b] >= high_cnt) begin
          high_cnt   = bin_count[b];
          r.peak_bin = BIN_W'(b);
        end
        if (bin_count[b] <= low_cnt) begin
          low_cnt    = bin_count[b];
          r.zero_bin = BIN_W'(b);
        end
        bin_count[b] = '0;
      end
      r.saturated = sat_seen;
      sat_seen    = 1'b0;
      pending_images.push_back(r);
      images_sent++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [BIN_W-1:0] want,
                                      input logic [BIN_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    image_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_images.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, actual peak=%0d zero=%0d sat=%0b",
                 $time, out_peak_bin, out_zero_bin, out_count_saturated);
      end else begin
        want = pending_images.pop_front();
        check_field("peak_bin", want.peak_bin, out_peak_bin);
        check_field("zero_bin", want.zero_bin, out_zero_bin);
        check_field("count_saturated", BIN_W'(want.saturated), BIN_W'(out_count_saturated));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one pixel word and wait for it to be taken
  task automatic send_pixel(input logic [BIN_W-1:0] px, input logic last);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_pixel <= BIN_W'($urandom);
      in_last_pixel <= 1'($urandom);
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start         <= 1'b1;
    in_pixel      <= px;
    in_last_pixel <= last;
    do @(posedge clk); while (busy !== 1'b0);
    count_pixel(px, last);
    pixels_sent++;
  endtask

  task automatic wait_for_results;
    @(negedge clk);
    start <= 1'b0;
    while (pending_images.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_pixel_images;
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd128, 1'b1);
  endtask

  task automatic test_tied_bins;
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd20, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd7, 1'b1);
  endtask

  // sender holds off until the scan result is back, then starts again
  task automatic test_pause_after_image;
    send_pixel(8'd170, 1'b0);
    send_pixel(8'd85, 1'b0);
    send_pixel(8'd85, 1'b1);
    wait_for_results();
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd1, 1'b1);
    send_pixel(8'd1, 1'b1);
  endtask

  task automatic send_random_image;
    int len;
    int style;
    int pick;
    logic [BIN_W-1:0] base;
    logic [BIN_W-1:0] px;
    pick  = $urandom_range(99);
    len   = (pick < 10) ? 1 : (pick < 85) ? $urandom_range(2, 12) : $urandom_range(13, 40);
    style = $urandom_range(3);
    base  = BIN_W'($urandom);
    for (int i = 0; i < len; i++) begin
      case (style)
        1: begin
          px = base + BIN_W'($urandom_range(3));
        end
        2: begin
          px = $urandom_range(1) ? 8'hFF : 8'h00;
          if ($urandom_range(3) == 0) px = px ^ 8'h01;
        end
        default: begin
          px = BIN_W'($urandom);
        end
      endcase
      send_pixel(px, i == len - 1);
    end
  endtask

  task automatic test_random_images(input int n_pixels, input int idle);
    int first;
    idle_pct = idle;
    first    = pixels_sent;
    while (pixels_sent - first < n_pixels) send_random_image();
  endtask

  // every bin filled once in a scattered order, up to three extra pixels on top
  task automatic test_all_bins_filled;
    int extras;
    int offs;
    int stride;
    extras = $urandom_range(0, 3);
    offs   = $urandom_range(255);
    stride = 2 * $urandom_range(127) + 1;
    for (int k = 0; k < NUM_BINS; k++)
      send_pixel(BIN_W'(offs + k * stride), (extras == 0) && (k == NUM_BINS - 1));
    for (int e = 0; e < extras; e++)
      send_pixel(BIN_W'($urandom), e == extras - 1);
  endtask

  initial begin
    for (int b = 0; b < NUM_BINS; b++) bin_count[b] = '0;
    sat_seen = 1'b0;
    idle_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_pixel_images();
    test_tied_bins();
    test_pause_after_image();
    test_random_images(40, 16);
    test_random_images(40, 67);
    test_random_images(40, 0);
    test_all_bins_filled();

    wait_for_results();
    repeat (SCAN_SETTLE) @(posedge clk);

    $display("Sent %0d pixels in %0d images; %0d results checked.",
             pixels_sent, images_sent, results_checked);
    $display("Covered single-pixel and tied images, idle sender phases and all bins filled.");
    if (mismatches == 0 && pending_images.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending_images.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_images.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
